[src/ffba_pkg.sv]
package ffba_pkg;

  localparam int POOL_SLOTS_DEF = 128;
  localparam int SLOT_W         = 8;   // table entry, also scan position
  localparam int SIZE_W         = 8;
  localparam int ADDR_W         = 8;
  localparam int START_W        = 7;
  localparam int S_TDATA_W      = SIZE_W + ADDR_W;
  localparam int M_TDATA_W      = 8;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic clear_step;     // write entry i with i, advance i
    logic load;           // take in a new item, start the table read
    logic scan_step;      // move the scan to the next position
    logic write_grant;    // mark the run start with the end of the run
    logic write_release;  // give the block start its own index back
    logic commit;         // place the result in the output register
    logic commit_ok;
  } ffba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_release;
    logic in_size_zero;
    logic in_addr_oob;
    logic scan_end;
    logic slot_free;
    logic run_hit;
    logic rel_is_start;
    logic out_busy;
  } ffba_status_t;

endpackage

[src/first_fit_block_allocator_core.sv]
// A request visits one table entry per step from slot 0 (free slots singly, blocks by their
//   stored end) until a free run of the requested size is found or the scan runs off the
//   end; a release reads and checks its entry; a zero size or bad address commits directly.
//   Commit waits while the output register holds an untaken result; one item at a time.
// Reset: synchronous rst, then a clearing pass writes each entry's own
//   index into the table; no item is accepted during that pass.
module first_fit_block_allocator_core #(
  parameter int POOL_SLOTS = ffba_pkg::POOL_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ffba_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] request_size, [15:8] release_address
  input  logic                           s_tuser,   // command: 0 request, 1 release
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ffba_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] block_start, [7] zero
  output logic                           m_tuser    // success
);

  ffba_pkg::ffba_cmd_t    cmd;
  ffba_pkg::ffba_status_t status;

  // The controller sequences clear, scan and release; it takes an item only when idle,
  // while an earlier result may still sit in the output register.
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the slot table, the scan position, run length and run start,
  // and the output register.
  ffba_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  // One item in flight: an accepted item closes the input until its result is placed.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is still in work");

  // The clearing pass follows reset, so no item is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during the table clearing pass");

  // A failed operation never reports a start slot.
  a_fail_zero_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed result carries a nonzero block_start");

endmodule

[src/ffba_ram.sv]
module ffba_ram #(
  parameter int WIDTH = ffba_pkg::SLOT_W,
  parameter int DEPTH = ffba_pkg::POOL_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ffba_ctrl.sv]
module ffba_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  ffba_pkg::ffba_status_t status,
  output ffba_pkg::ffba_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RCHK  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       ok;
  logic       ok_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ok_next    = ok;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          ok_next  = 1'b0;
          if (status.in_release) begin
            state_next = status.in_addr_oob ? ST_DONE : ST_RCHK;
          end else begin
            state_next = status.in_size_zero ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_end) begin
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end else if (status.slot_free && status.run_hit) begin
          cmd.write_grant = 1'b1;
          ok_next         = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_RCHK: begin
        cmd.write_release = status.rel_is_start;
        ok_next           = status.rel_is_start;
        state_next        = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.commit    = 1'b1;
          cmd.commit_ok = ok;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
    end
  end

endmodule

[src/ffba_dp.sv]
module ffba_dp #(
  parameter int POOL_SLOTS = ffba_pkg::POOL_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tuser,
  input  ffba_pkg::ffba_cmd_t              cmd,
  output ffba_pkg::ffba_status_t           status
);

  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CW    = ffba_pkg::SLOT_W;

  logic [CW-1:0]                    pos;       // scan position, also clear counter
  logic [CW-1:0]                    run;
  logic [CW-1:0]                    start;
  logic [ffba_pkg::SIZE_W-1:0]      size_q;
  logic [ffba_pkg::ADDR_W-1:0]      addr_q;
  logic                             rel_q;
  logic                             out_valid;
  logic                             out_success;
  logic [ffba_pkg::START_W-1:0]     out_start;

  logic [ffba_pkg::SIZE_W-1:0]      in_size;
  logic [ffba_pkg::ADDR_W-1:0]      in_addr;
  logic [CW-1:0]                    entry;
  logic [CW-1:0]                    pos_inc;
  logic [CW-1:0]                    run_inc;
  logic [CW-1:0]                    jump;
  logic [CW-1:0]                    pos_next;
  logic                             slot_free;
  logic                             we;
  logic [IDX_W-1:0]                 waddr;
  logic [CW-1:0]                    wdata;
  logic [IDX_W-1:0]                 raddr;

  assign in_size = s_tdata[ffba_pkg::SIZE_W-1:0];
  assign in_addr = s_tdata[ffba_pkg::S_TDATA_W-1:ffba_pkg::SIZE_W];

  assign pos_inc   = pos + CW'(1);
  assign run_inc   = run + CW'(1);
  assign slot_free = (entry == pos);
  // a stored end that does not lie ahead counts as a one-slot step
  assign jump      = (entry > pos) ? entry : pos_inc;
  assign pos_next  = slot_free ? pos_inc : jump;

  always_comb begin
    if (cmd.load) begin
      raddr = (s_tuser == ffba_pkg::CMD_RELEASE) ? in_addr[IDX_W-1:0] : '0;
    end else begin
      raddr = pos_next[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = pos;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.write_grant) begin
      we    = 1'b1;
      waddr = start[IDX_W-1:0];
      wdata = pos_inc;
    end else if (cmd.write_release) begin
      we    = 1'b1;
      waddr = addr_q[IDX_W-1:0];
      wdata = addr_q;
    end
  end

  ffba_ram #(
    .WIDTH (CW),
    .DEPTH (POOL_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (entry)
  );

  always_comb begin
    status              = '0;
    status.clear_last   = (pos == CW'(POOL_SLOTS - 1));
    status.in_release   = (s_tuser == ffba_pkg::CMD_RELEASE);
    status.in_size_zero = (in_size == '0);
    status.in_addr_oob  = (in_addr >= ffba_pkg::ADDR_W'(POOL_SLOTS));
    status.scan_end     = (pos >= CW'(POOL_SLOTS));
    status.slot_free    = slot_free;
    status.run_hit      = (run_inc == size_q);
    status.rel_is_start = (entry != addr_q);
    status.out_busy     = out_valid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.clear_step) begin
      pos <= pos_inc;
    end else if (cmd.load) begin
      pos <= '0;
    end else if (cmd.scan_step) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run    <= '0;
      start  <= '0;
      size_q <= in_size;
      addr_q <= in_addr;
      rel_q  <= s_tuser;
    end else if (cmd.scan_step) begin
      run   <= slot_free ? run_inc : '0;
      start <= slot_free ? start : jump;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_success <= cmd.commit_ok;
      out_start   <= (cmd.commit_ok && (rel_q == ffba_pkg::CMD_REQUEST)) ?
                     start[ffba_pkg::START_W-1:0] : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_success;
  assign m_tdata  = ffba_pkg::M_TDATA_W'(out_start);

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL        = ffba_pkg::POOL_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1470;
  localparam int TAIL_ITEMS   = 150;

  // One result item as the block reports it.
  typedef struct packed {
    logic       success;
    logic [6:0] block_start;
  } outcome_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [ffba_pkg::S_TDATA_W-1:0] s_tdata = '0;    // [7:0] request_size, [15:8] release_address
  logic                           s_tuser = 1'b0;  // command: 0 request, 1 release
  logic                           m_tvalid;
  logic                           m_tready = 1'b1;
  logic [ffba_pkg::M_TDATA_W-1:0] m_tdata;         // [6:0] block_start, [7] zero
  logic                           m_tuser;         // success

  // Shadow of the slot table: free and interior slots hold their own index,
  // a block start holds the index just past the block.
  logic [7:0] slot_map [POOL];
  outcome_t   pending_outcomes [$];

  bit quiet_tail;  // no idling on either side once set
  int error_count;
  int items_sent;
  int results_seen;
  int cycle_count;
  int grants;
  int releases;
  int refusals;
  int largest_grant;
  int live_blocks;
  int peak_blocks;
  int rx_stall_left;

  first_fit_block_allocator_core #(
    .POOL_SLOTS (POOL)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs or stops handshaking.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_outcomes.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver side: lower ready for random stretches, never during the quiet tail.
  always @(negedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left--;
    end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      rx_stall_left = $urandom_range(1, 3);
    end
    m_tready <= (rx_stall_left == 0);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // First-fit allocator behavior: scan from slot 0, hop over blocks by their
  // stored end, grant the first free run of the requested length.
  function automatic outcome_t predict_outcome(input logic cmd, input logic [7:0] size,
                                               input logic [7:0] addr);
    outcome_t res;
    int       run;
    int       first;
    int       pos;
    int       hop;
    res = '0;
    if (cmd == ffba_pkg::CMD_REQUEST) begin
      if (size != 0) begin
        run   = 0;
        first = 0;
        pos   = 0;
        while (pos < POOL && !res.success) begin
          if (slot_map[pos] == pos) begin
            run++;
            if (run == size) begin
              slot_map[first] = 8'(pos + 1);
              res.success     = 1'b1;
              res.block_start = 7'(first);
            end
            pos++;
          end else begin
            // A stored end at or below its own slot only advances by one.
            hop   = (slot_map[pos] > pos) ? int'(slot_map[pos]) : pos + 1;
            run   = 0;
            first = hop;
            pos   = hop;
          end
        end
      end
    end else if (addr < POOL && slot_map[addr] != addr) begin
      slot_map[addr] = addr;
      res.success    = 1'b1;
    end
    return res;
  endfunction

  // Drive one item from the falling edge, optionally after a short gap, and
  // hold it until the block takes it. Valid stays high afterwards so that
  // back-to-back items never see a lowered-then-raised valid in one step.
  task automatic send_item(input logic cmd, input logic [7:0] size, input logic [7:0] addr);
    int       gap;
    outcome_t res;
    gap = (!quiet_tail && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {addr, size};
    do @(posedge clk); while (!s_tready);
    res = predict_outcome(cmd, size, addr);
    pending_outcomes.push_back(res);
    items_sent++;
    if (!res.success) begin
      refusals++;
    end else if (cmd == ffba_pkg::CMD_REQUEST) begin
      grants++;
      live_blocks++;
      if (size > largest_grant) largest_grant = size;
      if (live_blocks > peak_blocks) peak_blocks = live_blocks;
    end else begin
      releases++;
      live_blocks--;
    end
  endtask

  // Drop valid and hold off until every pending result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Compare each accepted result against the oldest pending expectation.
  always @(posedge clk) begin : check_result
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("arrived with nothing pending, block_start", m_tdata[6:0], 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser !== want.success)
          report_mismatch("success", m_tuser, want.success);
        if (m_tdata[6:0] !== want.block_start)
          report_mismatch("block_start", m_tdata[6:0], want.block_start);
        if (m_tdata[7] !== 1'b0)
          report_mismatch("padding bit", m_tdata[7], 0);
      end
    end
  end

  // Size field edges: zero, beyond the pool, exactly the pool, then a request
  // for one slot that the full pool has no room for.
  task automatic test_size_edges();
    send_item(ffba_pkg::CMD_REQUEST, 8'd0, 8'hFF);     // zero size, address field ignored
    send_item(ffba_pkg::CMD_REQUEST, 8'd129, 8'h00);   // one more than the pool
    send_item(ffba_pkg::CMD_REQUEST, 8'd255, 8'h5A);   // largest size field
    send_item(ffba_pkg::CMD_REQUEST, 8'd128, 8'hA5);   // whole pool, granted at slot 0
    send_item(ffba_pkg::CMD_REQUEST, 8'd1, 8'h00);     // no room left
    send_item(ffba_pkg::CMD_RELEASE, 8'hFF, 8'd0);     // size field ignored on release
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd0);      // already free, not a block start
  endtask

  // Release errors against a pool holding two adjacent blocks.
  task automatic test_release_errors();
    send_item(ffba_pkg::CMD_REQUEST, 8'd10, 8'hAA);    // slots 0..9
    send_item(ffba_pkg::CMD_REQUEST, 8'd5, 8'h55);     // slots 10..14
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd12);     // inside a block
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd128);    // first address past the pool
    send_item(ffba_pkg::CMD_RELEASE, 8'hC3, 8'd255);   // largest address field
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd127);    // last slot, free
  endtask

  // Fill the tail, punch a hole and refill it first-fit, then clean up.
  task automatic test_first_fit_hole();
    send_item(ffba_pkg::CMD_REQUEST, 8'd113, 8'h00);   // slots 15..127, pool now full
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd10);     // hole of five at slot 10
    send_item(ffba_pkg::CMD_REQUEST, 8'd3, 8'h00);     // lands at slot 10
    send_item(ffba_pkg::CMD_REQUEST, 8'd3, 8'h00);     // only two left in the hole
    send_item(ffba_pkg::CMD_REQUEST, 8'd2, 8'h00);     // lands at slot 13
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd0);
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd10);
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd13);
    send_item(ffba_pkg::CMD_RELEASE, 8'd0, 8'd15);
  endtask

  // Mostly well-formed traffic: requests of mostly small sizes and releases
  // of live block starts, with some noise on every field mixed in.
  task automatic test_random_traffic(input int count);
    int         pick;
    int         live_starts [$];
    logic [7:0] size;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      live_starts.delete();
      for (int i = 0; i < POOL; i++)
        if (slot_map[i] != i) live_starts.push_back(i);
      if (pick < 45 || (pick < 85 && live_starts.size() == 0)) begin
        case ($urandom_range(0, 9))
          0:       size = 8'($urandom_range(1, 64));
          1:       size = 8'($urandom_range(0, 255));
          default: size = 8'($urandom_range(1, 12));
        endcase
        send_item(ffba_pkg::CMD_REQUEST, size, 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_item(ffba_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)),
                  8'(live_starts[$urandom_range(0, live_starts.size() - 1)]));
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Let the pipeline run dry in the middle of traffic, then resume.
  task automatic test_drain_pause();
    test_random_traffic(6);
    wait_drained();
    test_random_traffic(6);
  endtask

  // Final stretch with both sides always ready.
  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    test_random_traffic(TAIL_ITEMS);
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) slot_map[i] = 8'(i);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_size_edges();
    test_release_errors();
    test_first_fit_hole();
    test_random_traffic(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS / 2);
    test_quiet_tail();

    // Wait out the last results, then leave room for any stray output.
    wait_drained();
    repeat (POOL + 4) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch("results never arrived, count", 0, pending_outcomes.size());

    $display("%0d items: %0d grants (largest %0d slots), %0d releases, %0d refusals",
             items_sent, grants, largest_grant, releases, refusals);
    $display("up to %0d blocks live at once; %0d results checked, %0d mismatches",
             peak_blocks, results_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
